>>> src/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg: shared types and constants of the bounded circular list engine
// Opcodes, status codes, sizes and the control/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bcle_pkg;
   localparam int DEPTH   = 16;
   localparam int POS_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_REM_FRONT = 3'd2,
      OP_REM_BACK  = 3'd3,
      OP_REM_VALUE = 3'd4,
      OP_SEARCH    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic execute;  // apply operation and report
   } dp_cmd_type;

   // datapath to controller (loaded gates the execute command)
   typedef struct packed {
      logic loaded;
   } dp_status_type;
endpackage
`default_nettype wire

>>> src/bcle_datapath.sv
// ----------------------------------------------------------------------------
// bcle_datapath: compare-and-shift cell row
// Each cell compares its entry to the operand; shifting compacts or opens
// the row.
// ----------------------------------------------------------------------------
`default_nettype none
module bcle_datapath import bcle_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dp_cmd_type                cmd,
   output dp_status_type                  status,
   input  wire logic [2:0]                req_opcode,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic [1:0]                     rsp_status,
   output logic signed [VALUE_W-1:0]      rsp_removed_value,
   output logic [3:0]                     rsp_match_position,
   output logic [4:0]                     rsp_element_count
);
   logic [VALUE_W-1:0] cell_ff [DEPTH];
   logic [VALUE_W-1:0] cell_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [2:0]         op_ff;
   logic [VALUE_W-1:0] val_ff;
   logic               loaded_ff;
   logic [DEPTH-1:0]   hit;
   logic [DEPTH-1:0]   first;
   logic [POS_W-1:0]   hit_pos;
   logic               found;
   logic [CNT_W-1:0]   rpos;
   logic               full, empty;
   logic [1:0]         st;
   logic [VALUE_W-1:0] removed;
   logic [POS_W-1:0]   mpos;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign status.loaded = loaded_ff;

   // match cells, then a one-hot first-hit chain
   always_comb begin
      for (int i = 0; i < DEPTH; i++)
         hit[i] = (cell_ff[i] == val_ff) && (CNT_W'(i) < count_ff);
      first = hit & (~hit + DEPTH'(1));
      found = |hit;
      hit_pos = '0;
      for (int i = 0; i < DEPTH; i++)
         if (first[i]) hit_pos = POS_W'(i);
   end

   always_comb begin
      st       = ST_OK;
      removed  = '0;
      mpos     = '0;
      count_in = count_ff;
      rpos     = count_ff;   // no removal
      for (int i = 0; i < DEPTH; i++) cell_in[i] = cell_ff[i];
      unique case (op_ff)
         OP_INS_FRONT: begin
            if (full) st = ST_FULL;
            else begin
               for (int i = 1; i < DEPTH; i++) cell_in[i] = cell_ff[i-1];
               cell_in[0] = val_ff;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INS_BACK: begin
            if (full) st = ST_FULL;
            else begin
               cell_in[count_ff[POS_W-1:0]] = val_ff;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REM_FRONT: begin
            if (empty) st = ST_EMPTY;
            else rpos = '0;
         end
         OP_REM_BACK: begin
            if (empty) st = ST_EMPTY;
            else rpos = count_ff - 1'b1;
         end
         OP_REM_VALUE: begin
            if (empty) st = ST_EMPTY;
            else if (!found) st = ST_NOT_FOUND;
            else rpos = CNT_W'(hit_pos);
         end
         OP_SEARCH: begin
            if (!found) st = ST_NOT_FOUND;
            else mpos = hit_pos;
         end
         default: ;
      endcase
      if (rpos != count_ff) begin
         removed  = cell_ff[rpos[POS_W-1:0]];
         count_in = count_ff - 1'b1;
         // close the gap
         for (int i = 0; i < DEPTH - 1; i++)
            if (CNT_W'(i) >= rpos) cell_in[i] = cell_ff[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         loaded_ff <= 1'b0;
      end else begin
         loaded_ff <= cmd.load;
         if (cmd.execute) count_ff <= count_in;
      end
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= req_value;
      end
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) cell_ff[i] <= cell_in[i];
         rsp_status         <= st;
         rsp_removed_value  <= removed;
         rsp_match_position <= 4'(mpos);
         rsp_element_count  <= 5'(count_in);
      end
   end
endmodule
`default_nettype wire

>>> src/bcle_control.sv
// ----------------------------------------------------------------------------
// bcle_control: request sequencer
// Captures a request, runs the execute state, then strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none
module bcle_control import bcle_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type dp_status,
   output dp_cmd_type         cmd,
   output logic               busy,
   output logic               rsp_valid
);
   fsm_type state_ff, state_in;
   logic    valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= cmd.execute;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            busy        = 1'b1;
            cmd.execute = dp_status.loaded;
            state_in    = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

>>> src/bounded_circular_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_circular_list_engine_unit: ordered deque with search
// A request is captured at the accepting start edge; the execute state then
// registers the result and raises rsp_valid.
// busy holds off new requests while one is in the execute state
// (capture, then execute in the compare-and-shift cell row).
// Reset clears the element count; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none
module bounded_circular_list_engine_unit import bcle_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_removed_value,
   output logic [3:0]              rsp_match_position,
   output logic [4:0]              rsp_element_count
);
   dp_cmd_type    cmd;
   dp_status_type dp_status;

   bcle_control u_control (
      .clock, .reset, .start, .dp_status, .cmd, .busy, .rsp_valid
   );

   bcle_datapath u_datapath (
      .clock, .reset, .cmd, .status(dp_status),
      .req_opcode, .req_value,
      .rsp_status, .rsp_removed_value, .rsp_match_position, .rsp_element_count
   );
endmodule
`default_nettype wire

>>> dv/bounded_circular_list_engine_checker.sv
// ----------------------------------------------------------------------------
// bounded_circular_list_engine_checker: list predictor and result scoreboard
// Watches accepted requests, predicts each response from a private copy of
// the list and compares every strobed response field by field.
// ----------------------------------------------------------------------------
module bounded_circular_list_engine_checker import bcle_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [31:0] req_value,
   input  wire logic               rsp_valid,
   input  wire logic [1:0]         rsp_status,
   input  wire logic signed [31:0] rsp_removed_value,
   input  wire logic [3:0]         rsp_match_position,
   input  wire logic [4:0]         rsp_element_count,
   output int                      fail_count,
   output int                      pending_count
);
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] removed;
      logic [3:0]  pos;
      logic [4:0]  count;
   } list_rsp_type;

   logic [31:0]  list_q[$];
   list_rsp_type rsp_q[$];

   function automatic list_rsp_type apply_op(logic [2:0] op, logic [31:0] v);
      list_rsp_type r;
      int           hit;
      r   = '0;
      hit = -1;
      for (int i = 0; i < list_q.size(); i++)
         if (hit < 0 && list_q[i] == v) hit = i;
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (list_q.size() >= DEPTH) r.status = ST_FULL;
            else if (op == OP_INS_FRONT) list_q.push_front(v);
            else list_q.push_back(v);
         end
         OP_REM_FRONT: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            else r.removed = list_q.pop_front();
         end
         OP_REM_BACK: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            else r.removed = list_q.pop_back();
         end
         OP_REM_VALUE: begin
            if (list_q.size() == 0) r.status = ST_EMPTY;
            else if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               r.removed = list_q[hit];
               list_q.delete(hit);
            end
         end
         OP_SEARCH: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else r.pos = hit[3:0];
         end
         default: ;
      endcase
      r.count = 5'(list_q.size());
      return r;
   endfunction

   assign pending_count = rsp_q.size();

   always @(posedge clock) begin
      list_rsp_type exp_rsp;
      if (reset) begin
         list_q.delete();
         rsp_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (rsp_q.size() == 0) begin
               $error("response with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = rsp_q.pop_front();
               if (rsp_status !== exp_rsp.status ||
                   rsp_removed_value !== exp_rsp.removed ||
                   rsp_match_position !== exp_rsp.pos ||
                   rsp_element_count !== exp_rsp.count)
                  fail_count <= fail_count + 1;
               if (rsp_status !== exp_rsp.status)
                  $error("status expected %0d got %0d", exp_rsp.status, rsp_status);
               if (rsp_removed_value !== exp_rsp.removed)
                  $error("removed_value expected %h got %h", exp_rsp.removed,
                         rsp_removed_value);
               if (rsp_match_position !== exp_rsp.pos)
                  $error("match_position expected %0d got %0d", exp_rsp.pos,
                         rsp_match_position);
               if (rsp_element_count !== exp_rsp.count)
                  $error("element_count expected %0d got %0d", exp_rsp.count,
                         rsp_element_count);
            end
         end
         // predict after the compare so a same-edge transfer queues behind
         if (start && !busy) rsp_q.push_back(apply_op(req_opcode, req_value));
      end
   end
endmodule

>>> dv/bounded_circular_list_engine_unit_test.sv
// ----------------------------------------------------------------------------
// bounded_circular_list_engine_unit_test: stimulus and verdict
// Drives directed list operations, then random fill/drain sequences with
// values from a small pool so that searches and removes hit, with gaps.
// ----------------------------------------------------------------------------
module bounded_circular_list_engine_unit_test;
   import bcle_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [2:0]         req_opcode = '0;
   logic signed [31:0] req_value = '0;
   logic               busy, rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic [3:0]         rsp_match_position;
   logic [4:0]         rsp_element_count;
   int                 fail_count, pending_count;
   int                 cycle_count = 0;
   logic [31:0]        value_pool[8];
   bit                 no_gaps = 1'b0;

   always #10 clock = ~clock;

   bounded_circular_list_engine_unit uut (.*);
   bounded_circular_list_engine_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[bounded_circular_list_engine_unit] ERROR");
         $finish;
      end
   end

   // start stays high after a transfer; busy masks it until the next one
   task automatic send_op(logic [2:0] op, logic [31:0] v);
      if (!no_gaps)
         while ($urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(9) < 8) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   initial begin
      logic [2:0] op;
      int         phase_len, bias;
      value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0,
                     32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // empty-list cases, fill past full, search, removes, bad opcodes
      send_op(OP_REM_FRONT, 32'h0);
      send_op(OP_REM_BACK, 32'h0);
      send_op(OP_REM_VALUE, 32'h1);
      send_op(OP_SEARCH, 32'h1);
      for (int i = 0; i < 9; i++) send_op(OP_INS_BACK, value_pool[i % 8]);
      for (int i = 0; i < 8; i++) send_op(OP_INS_FRONT, ~value_pool[i]);
      send_op(OP_SEARCH, 32'h8000_0000);
      send_op(OP_SEARCH, 32'h1234_5678);
      send_op(OP_REM_VALUE, 32'h2222_2222);
      send_op(OP_REM_VALUE, 32'h8000_0000);
      send_op(3'd6, 32'h0);
      send_op(3'd7, 32'hffff_ffff);
      send_op(OP_REM_FRONT, 32'h0);
      send_op(OP_REM_BACK, 32'h0);
      // hold off until the list engine has drained every response
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int ph = 0; ph < 26; ph++) begin
         no_gaps   = (ph == 10);
         bias      = (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 30 : 50;
         phase_len = 50;
         for (int n = 0; n < phase_len; n++) begin
            if ($urandom_range(99) < 3) op = 3'($urandom_range(7, 6));
            else if ($urandom_range(99) < bias) op = 3'($urandom_range(1));
            else op = 3'($urandom_range(5, 2));
            send_op(op, pick_value());
         end
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("[bounded_circular_list_engine_unit] OK");
      else $display("[bounded_circular_list_engine_unit] ERROR");
      $finish;
   end
endmodule
